[hdl/dtd_pkg.sv]
package dtd_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned BITS_W  = 30;
	localparam int unsigned SMP_W   = 12;
	localparam int unsigned STAMP_W = 48;
	localparam int unsigned LEN_W   = 36;

	typedef enum logic [2:0] {
		TAG_HDR0,
		TAG_HDR1,
		TAG_HDR2,
		TAG_HDR3,
		TAG_TRACE
	} dtd_tag_t;

	typedef enum logic {
		PH_HEADER,
		PH_TRACE
	} dtd_phase_t;

	typedef enum logic {
		KIND_HEADER = 1'b0,
		KIND_SAMPLE = 1'b1
	} dtd_kind_t;

	typedef struct packed {
		dtd_tag_t            tag;
		logic [BITS_W-1:0]   bits;
		logic [1:0]          count;
		logic                last;
	} dtd_entry_t;

	typedef struct packed {
		dtd_kind_t           kind;
		logic [1:0]          channel;
		logic [SMP_W-1:0]    sample_a;
		logic [SMP_W-1:0]    sample_b;
		logic [1:0]          sample_count;
		logic [STAMP_W-1:0]  time_stamp;
		logic [LEN_W-1:0]    trace_length;
		logic                wrap_flag;
		logic [1:0]          stop_delay;
		logic [3:0]          trigger_count;
		logic [3:0]          extra_header;
		logic                last;
	} dtd_result_t;

endpackage

[hdl/dtd_word_if.sv]
interface dtd_word_if;
	logic        valid;
	logic        ready;
	logic [31:0] word;

	modport source (output valid, output word, input ready);
	modport sink (input valid, input word, output ready);
endinterface

[hdl/dtd_result_if.sv]
interface dtd_result_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [1:0]  channel;
	logic [11:0] sample_a;
	logic [11:0] sample_b;
	logic [1:0]  sample_count;
	logic [47:0] time_stamp;
	logic [35:0] trace_length;
	logic        wrap_flag;
	logic [1:0]  stop_delay;
	logic [3:0]  trigger_count;
	logic [3:0]  extra_header;
	logic        last;

	modport source (
		output valid, output kind, output channel, output sample_a, output sample_b,
		output sample_count, output time_stamp, output trace_length, output wrap_flag,
		output stop_delay, output trigger_count, output extra_header, output last,
		input ready
	);
	modport sink (
		input valid, input kind, input channel, input sample_a, input sample_b,
		input sample_count, input time_stamp, input trace_length, input wrap_flag,
		input stop_delay, input trigger_count, input extra_header, input last,
		output ready
	);
endinterface

[hdl/dtd_front.sv]
module dtd_front (
	input  logic                clk,
	input  logic                arst_n,
	dtd_word_if.sink            words,
	input  logic                full,
	output logic                push,
	output dtd_pkg::dtd_entry_t push_data
);
	import dtd_pkg::*;

	dtd_phase_t          phase_q, phase_d;
	logic [1:0]          hidx_q;
	logic [SMP_W-1:0]    len_hi_q;
	logic [LEN_W-1:0]    rem_q;
	logic [LEN_W-1:0]    len;
	logic                rem_ge2;
	logic                accept;

	assign words.ready = ~full;
	assign accept      = words.valid & ~full;
	assign push        = accept;
	assign len         = {len_hi_q, words.word[27:16], words.word[11:0]};
	assign rem_ge2     = |rem_q[LEN_W-1:1];

	always_comb begin
		phase_d = phase_q;
		if (accept) begin
			unique case (phase_q)
				PH_HEADER: begin
					if (hidx_q == 2'd3 && len != '0)
						phase_d = PH_TRACE;
				end
				PH_TRACE: begin
					if (~rem_ge2 || rem_q == LEN_W'(2))
						phase_d = PH_HEADER;
				end
				default: phase_d = PH_HEADER;
			endcase
		end
	end

	always_comb begin
		push_data.bits  = words.word[BITS_W-1:0];
		push_data.tag   = TAG_TRACE;
		push_data.count = 2'd0;
		push_data.last  = 1'b0;
		unique case (phase_q)
			PH_HEADER: begin
				unique case (hidx_q)
					2'd0: push_data.tag = TAG_HDR0;
					2'd1: push_data.tag = TAG_HDR1;
					2'd2: push_data.tag = TAG_HDR2;
					default: begin
						push_data.tag  = TAG_HDR3;
						push_data.last = (len == '0);
					end
				endcase
			end
			PH_TRACE: begin
				push_data.tag   = TAG_TRACE;
				push_data.count = rem_ge2 ? 2'd2 : rem_q[1:0];
				push_data.last  = ~rem_ge2 || rem_q == LEN_W'(2);
			end
			default: push_data.tag = TAG_TRACE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			hidx_q  <= 2'd0;
			rem_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			if (phase_q == PH_HEADER) begin
				hidx_q <= hidx_q + 2'd1;
				if (hidx_q == 2'd3)
					rem_q <= len;
			end else begin
				hidx_q <= 2'd0;
				rem_q  <= rem_q - LEN_W'(push_data.count);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && phase_q == PH_HEADER && hidx_q == 2'd2)
			len_hi_q <= words.word[11:0];
	end

endmodule

[hdl/dtd_queue.sv]
module dtd_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  dtd_pkg::dtd_entry_t push_data,
	output logic                full,
	input  logic                pop,
	output dtd_pkg::dtd_entry_t pop_data,
	output logic                empty
);
	import dtd_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	dtd_entry_t        mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_q, rd_q;
	logic [CNT_W-1:0]  cnt_q;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			if (pop)
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("queue pop while empty");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("queue fill count out of range");
	a_cnt_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + CNT_W'(1))
		else $error("queue fill count lost a request");
`endif

endmodule

[hdl/dtd_back.sv]
module dtd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                empty,
	input  dtd_pkg::dtd_entry_t pop_data,
	output logic                pop,
	dtd_result_if.source        results
);
	import dtd_pkg::*;

	logic [1:0]          ch_q;
	logic [STAMP_W-1:0]  ts_q;
	logic                wrap_q;
	logic [1:0]          delay_q;
	logic [3:0]          trig_q;
	logic [3:0]          extra_q;
	logic [LEN_W-1:0]    len_q;
	logic                out_valid_q;
	dtd_result_t         out_q;
	dtd_result_t         res;
	logic                info_only;
	logic                take;
	logic [SMP_W-1:0]    lo, hi;

	assign lo        = pop_data.bits[11:0];
	assign hi        = pop_data.bits[27:16];
	assign info_only = pop_data.tag == TAG_HDR0 || pop_data.tag == TAG_HDR1 ||
	                   pop_data.tag == TAG_HDR2;
	assign take      = ~out_valid_q | results.ready;
	assign pop       = ~empty & (info_only | take);

	always_comb begin
		res.kind          = KIND_HEADER;
		res.channel       = ch_q;
		res.sample_a      = '0;
		res.sample_b      = '0;
		res.sample_count  = 2'd0;
		res.time_stamp    = ts_q;
		res.trace_length  = len_q;
		res.wrap_flag     = wrap_q;
		res.stop_delay    = delay_q;
		res.trigger_count = trig_q;
		res.extra_header  = extra_q;
		res.last          = pop_data.last;
		if (pop_data.tag == TAG_HDR3) begin
			res.trace_length = {len_q[LEN_W-1:24], hi, lo};
		end else begin
			res.kind         = KIND_SAMPLE;
			res.sample_a     = lo;
			res.sample_b     = (pop_data.count == 2'd2) ? hi : '0;
			res.sample_count = pop_data.count;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			unique case (pop_data.tag)
				TAG_HDR0: begin
					ch_q         <= pop_data.bits[29:28];
					ts_q[47:24]  <= {hi, lo};
				end
				TAG_HDR1: ts_q[23:0] <= {hi, lo};
				TAG_HDR2: begin
					wrap_q       <= pop_data.bits[27];
					delay_q      <= pop_data.bits[25:24];
					trig_q       <= pop_data.bits[23:20];
					extra_q      <= pop_data.bits[19:16];
					len_q[35:24] <= lo;
				end
				TAG_HDR3: begin
					len_q[23:0]  <= {hi, lo};
					out_q        <= res;
				end
				TAG_TRACE: out_q <= res;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (pop && !info_only)
			out_valid_q <= 1'b1;
		else if (results.ready)
			out_valid_q <= 1'b0;
	end

	assign results.valid         = out_valid_q;
	assign results.kind          = out_q.kind;
	assign results.channel       = out_q.channel;
	assign results.sample_a      = out_q.sample_a;
	assign results.sample_b      = out_q.sample_b;
	assign results.sample_count  = out_q.sample_count;
	assign results.time_stamp    = out_q.time_stamp;
	assign results.trace_length  = out_q.trace_length;
	assign results.wrap_flag     = out_q.wrap_flag;
	assign results.stop_delay    = out_q.stop_delay;
	assign results.trigger_count = out_q.trigger_count;
	assign results.extra_header  = out_q.extra_header;
	assign results.last          = out_q.last;

endmodule

[hdl/digitizer_trace_demux.sv]
// Channel   Dir  Payload
// words     in   word[31:0] readout word
// results   out  kind, channel, samples a/b, sample_count, header fields, last
//
// One readout word per cycle unless the queue is full; each result is registered.
// Header words 0 to 2 give no result; word 3 and every trace word give one.
// The front stalls only when the word queue is full; the back stalls on results.ready.
// Reset clears the parser state, the queue and the output valid.
module digitizer_trace_demux #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	dtd_word_if.sink      words,
	dtd_result_if.source  results
);
	import dtd_pkg::*;

	logic       push, pop, full, empty;
	dtd_entry_t push_data, pop_data;

	dtd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.words     (words),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	dtd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	dtd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (empty),
		.pop_data (pop_data),
		.pop      (pop),
		.results  (results)
	);

endmodule

[verif/dtd_checker.sv]
`timescale 1ns / 100ps

module dtd_checker (
	input  logic  clk,
	input  logic  arst_n,
	dtd_word_if   words,
	dtd_result_if results,
	output int    mismatches,
	output int    outstanding,
	output int    compared
);
	import dtd_pkg::*;

	dtd_result_t        pending_results[$];
	dtd_phase_t         phase;
	dtd_tag_t           next_hdr;
	logic [1:0]         chan;
	logic [STAMP_W-1:0] stamp;
	logic               wrap;
	logic [1:0]         delay;
	logic [3:0]         trig;
	logic [3:0]         extra;
	logic [LEN_W-1:0]   len;
	logic [LEN_W-1:0]   done;

	task automatic demux_word(input logic [WORD_W-1:0] w);
		dtd_result_t      r;
		logic [SMP_W-1:0] lo;
		logic [SMP_W-1:0] hi;
		logic [LEN_W-1:0] left;
		logic [1:0]       cnt;
		lo = w[11:0];
		hi = w[27:16];
		if (phase == PH_HEADER) begin
			case (next_hdr)
				TAG_HDR0: begin
					chan     = w[29:28];
					stamp    = {hi, lo, 24'h0};
					next_hdr = TAG_HDR1;
				end
				TAG_HDR1: begin
					stamp[23:0] = {hi, lo};
					next_hdr    = TAG_HDR2;
				end
				TAG_HDR2: begin
					wrap     = w[27];
					delay    = w[25:24];
					trig     = w[23:20];
					extra    = w[19:16];
					len      = {lo, 24'h0};
					next_hdr = TAG_HDR3;
				end
				default: begin
					len[23:0] = {hi, lo};
					next_hdr  = TAG_HDR0;
					done      = '0;
					phase     = (len != 0) ? PH_TRACE : PH_HEADER;
				end
			endcase
			if (next_hdr != TAG_HDR0)
				return;
			r.kind         = KIND_HEADER;
			r.sample_a     = '0;
			r.sample_b     = '0;
			r.sample_count = '0;
			r.last         = (len == 0);
		end else begin
			left  = len - done;
			cnt   = (left >= 2) ? 2'd2 : left[1:0];
			done  = done + LEN_W'(cnt);
			r.kind         = KIND_SAMPLE;
			r.sample_a     = lo;
			r.sample_b     = (cnt == 2'd2) ? hi : '0;
			r.sample_count = cnt;
			r.last         = (done >= len);
			if (r.last) begin
				phase    = PH_HEADER;
				next_hdr = TAG_HDR0;
			end
		end
		r.channel       = chan;
		r.time_stamp    = stamp;
		r.trace_length  = len;
		r.wrap_flag     = wrap;
		r.stop_delay    = delay;
		r.trigger_count = trig;
		r.extra_header  = extra;
		pending_results.push_back(r);
	endtask

	task automatic check_field(input string fname, input logic [63:0] e, input logic [63:0] a);
		if (e !== a) begin
			$error("%s: expected 0x%0h, got 0x%0h", fname, e, a);
			mismatches++;
		end
	endtask

	task automatic take_result();
		dtd_result_t e;
		if (pending_results.size() == 0) begin
			$error("result request with nothing expected");
			mismatches++;
			return;
		end
		e = pending_results.pop_front();
		compared++;
		check_field("kind", e.kind, results.kind);
		check_field("channel", e.channel, results.channel);
		check_field("sample_a", e.sample_a, results.sample_a);
		check_field("sample_b", e.sample_b, results.sample_b);
		check_field("sample_count", e.sample_count, results.sample_count);
		check_field("time_stamp", e.time_stamp, results.time_stamp);
		check_field("trace_length", e.trace_length, results.trace_length);
		check_field("wrap_flag", e.wrap_flag, results.wrap_flag);
		check_field("stop_delay", e.stop_delay, results.stop_delay);
		check_field("trigger_count", e.trigger_count, results.trigger_count);
		check_field("extra_header", e.extra_header, results.extra_header);
		check_field("last", e.last, results.last);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase       = PH_HEADER;
			next_hdr    = TAG_HDR0;
			chan        = '0;
			stamp       = '0;
			wrap        = 1'b0;
			delay       = '0;
			trig        = '0;
			extra       = '0;
			len         = '0;
			done        = '0;
			mismatches  = 0;
			compared    = 0;
			pending_results.delete();
			outstanding <= 0;
		end else begin
			// a result leaving now always belongs to an earlier request
			if (results.valid && results.ready)
				take_result();
			if (words.valid && words.ready)
				demux_word(words.word);
			outstanding <= pending_results.size();
		end
	end

endmodule

[verif/tb_digitizer_trace_demux.sv]
`timescale 1ns / 100ps

module tb_digitizer_trace_demux;
	import dtd_pkg::*;

	localparam int LONG_HOLD      = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_WORDS    = 500;

	logic clk;
	logic arst_n;

	dtd_word_if   words();
	dtd_result_if results();

	int mismatches;
	int outstanding;
	int compared;

	int send_gap_pct = 29;
	int rx_stall_pct = 72;
	int hold_asked   = 0;
	int hold_served  = 0;
	int hold_left    = 0;
	int quiet_cycles = 0;
	int words_sent   = 0;
	int records_sent = 0;

	digitizer_trace_demux u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.words   (words),
		.results (results)
	);

	dtd_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.words       (words),
		.results     (results),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.compared    (compared)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// receiver: random stalls, plus one long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results.ready <= 1'b0;
		end else if (hold_left != 0) begin
			results.ready <= 1'b0;
			hold_left     <= hold_left - 1;
		end else if (hold_asked != hold_served) begin
			hold_served   <= hold_asked;
			hold_left     <= LONG_HOLD;
			results.ready <= 1'b0;
		end else begin
			results.ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((words.valid && words.ready) || (results.valid && results.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("digitizer_trace_demux regression: fail");
			$finish;
		end
	end

	task automatic push_word(input logic [WORD_W-1:0] w);
		if ($urandom_range(99) < send_gap_pct) begin
			words.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
		end
		words.valid <= 1'b1;
		words.word  <= w;
		do @(posedge clk); while (!words.ready);
		words_sent++;
	endtask

	task automatic send_header(input logic [1:0] chan, input logic [STAMP_W-1:0] stamp,
			input logic wrap, input logic [1:0] delay, input logic [3:0] trig,
			input logic [3:0] extra, input logic [LEN_W-1:0] len);
		logic [31:0] f0;
		logic [31:0] f1;
		logic [31:0] f2;
		logic [31:0] f3;
		f0 = $urandom;
		f1 = $urandom;
		f2 = $urandom;
		f3 = $urandom;
		push_word({f0[31:30], chan, stamp[47:36], f0[15:12], stamp[35:24]});
		push_word({f1[31:28], stamp[23:12], f1[15:12], stamp[11:0]});
		push_word({f2[31:28], wrap, f2[26], delay, trig, extra, f2[15:12], len[35:24]});
		push_word({f3[31:28], len[23:12], f3[15:12], len[11:0]});
		records_sent++;
	endtask

	task automatic send_trace(input int n);
		repeat (n) push_word($urandom);
	endtask

	task automatic send_record(input logic [LEN_W-1:0] len);
		send_header(2'($urandom_range(3)), STAMP_W'({$urandom, $urandom}),
			1'($urandom_range(1)), 2'($urandom_range(3)), 4'($urandom_range(15)),
			4'($urandom_range(15)), len);
		send_trace(int'((len + LEN_W'(1)) / 2));
	endtask

	task automatic random_records(input int upto);
		int pick;
		while (words_sent < upto) begin
			pick = $urandom_range(99);
			if (pick < 15)
				send_record('0);
			else if (pick < 90)
				send_record(LEN_W'($urandom_range(24, 1)));
			else
				send_record(LEN_W'($urandom_range(300, 25)));
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		words.valid   = 1'b0;
		words.word    = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty trace, single odd sample, one full word, odd length over two words
		send_header(2'd0, '0, 1'b0, 2'd0, 4'd0, 4'd0, 36'd0);
		send_header(2'd3, '1, 1'b1, 2'd3, 4'd15, 4'd15, 36'd1);
		push_word(32'hffff_ffff);
		send_header(2'd2, 48'h8000_0000_0001, 1'b0, 2'd1, 4'd8, 4'd1, 36'd2);
		push_word(32'h0000_0000);
		send_header(2'd1, 48'h1234_5678_9abc, 1'b1, 2'd2, 4'd4, 4'd7, 36'd3);
		push_word(32'h0fff_0fff);
		push_word(32'hf000_f000);

		random_records(words_sent + PHASE_WORDS);

		send_gap_pct  = 72;
		rx_stall_pct <= 29;
		random_records(words_sent + PHASE_WORDS);

		send_gap_pct  = 0;
		rx_stall_pct <= 0;
		hold_asked   <= hold_asked + 1;
		send_record(36'd80);
		random_records(words_sent + PHASE_WORDS);

		// maximal length: never completes, stream ends mid-trace
		send_header(2'($urandom_range(3)), '1, 1'b1, 2'd3, 4'd15, 4'd15, '1);
		send_trace(16);

		words.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d readout words in %0d records, %0d results compared",
			words_sent, records_sent, compared);
		if (mismatches == 0)
			$display("digitizer_trace_demux regression: pass");
		else
			$display("digitizer_trace_demux regression: fail");
		$finish;
	end

endmodule

[digitizer_trace_demux.f]
hdl/dtd_pkg.sv
hdl/dtd_word_if.sv
hdl/dtd_result_if.sv
hdl/dtd_front.sv
hdl/dtd_queue.sv
hdl/dtd_back.sv
hdl/digitizer_trace_demux.sv
verif/dtd_checker.sv
verif/tb_digitizer_trace_demux.sv
